[rtl/splc_pkg.sv]
// ---------------------------------------------------------------------------
// splc_pkg
// Shared widths, register indexes, result codes and structs of the sensor
// packet receiver with level conversion.
// ---------------------------------------------------------------------------
package splc_pkg;

  localparam int VOLT_W    = 22;  // voltage limits and offset
  localparam int FACTOR_W  = 16;  // conversion factor
  localparam int LEVEL_W   = 16;  // level limits
  localparam int AGE_W     = 16;  // tick age and timeout
  localparam int SAMPLE_W  = 16;  // stored voltage reading
  localparam int WLEVEL_W  = 24;  // computed water level, signed
  localparam int BYTE_W    = 8;
  localparam int EVENT_W   = 2;
  localparam int STATUS_W  = 2;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_MIN_VOLTAGE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_VOLTAGE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_OFFSET  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VOLTS_PER_LEVEL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_LEVEL       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS   = 3'd6;

  // Register reset values.
  localparam logic [VOLT_W-1:0]   RST_MIN_VOLTAGE     = 22'd500000;
  localparam logic [VOLT_W-1:0]   RST_MAX_VOLTAGE     = 22'd2500000;
  localparam logic [VOLT_W-1:0]   RST_VOLTAGE_OFFSET  = 22'd500000;
  localparam logic [FACTOR_W-1:0] RST_VOLTS_PER_LEVEL = 16'd2105;
  localparam logic [LEVEL_W-1:0]  RST_MIN_LEVEL       = 16'd50;
  localparam logic [LEVEL_W-1:0]  RST_MAX_LEVEL       = 16'd1000;
  localparam logic [AGE_W-1:0]    RST_TIMEOUT_TICKS   = 16'd1500;

  // Input word kinds.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Frame event codes.
  localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EVENT_W-1:0] EV_ACCEPTED = 2'd1;
  localparam logic [EVENT_W-1:0] EV_CHECKSUM = 2'd2;
  localparam logic [EVENT_W-1:0] EV_COUNTER  = 2'd3;

  // Level status codes.
  localparam logic [STATUS_W-1:0] LS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] LS_VOLT_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] LS_LEVEL_RANGE = 2'd2;

  typedef struct packed {
    logic [VOLT_W-1:0]   min_voltage;
    logic [VOLT_W-1:0]   max_voltage;
    logic [VOLT_W-1:0]   voltage_offset;
    logic [FACTOR_W-1:0] volts_per_level;
    logic [LEVEL_W-1:0]  min_level;
    logic [LEVEL_W-1:0]  max_level;
    logic [AGE_W-1:0]    timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [EVENT_W-1:0]  event_code;
    logic [SAMPLE_W-1:0] voltage;
    logic [AGE_W-1:0]    tick_age;
  } frame_stat_t;

endpackage

[rtl/splc_if.sv]
// ---------------------------------------------------------------------------
// splc_if
// Valid/ready channels of the sensor packet receiver: the input word
// channel and the result word channel.
// ---------------------------------------------------------------------------
interface splc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [splc_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface splc_out_if;
  logic                                valid;
  logic                                ready;
  logic [splc_pkg::EVENT_W-1:0]        packet_event;
  logic                                timed_out;
  logic [splc_pkg::STATUS_W-1:0]       level_status;
  logic signed [splc_pkg::WLEVEL_W-1:0] water_level;
  logic [splc_pkg::SAMPLE_W-1:0]       voltage_out;

  modport source (output valid, output packet_event, output timed_out,
                  output level_status, output water_level, output voltage_out,
                  input ready);
  modport sink   (input valid, input packet_event, input timed_out,
                  input level_status, input water_level, input voltage_out,
                  output ready);
endinterface

[rtl/splc_cfg.sv]
// ---------------------------------------------------------------------------
// splc_cfg
// APB register file holding the conversion limits and the timeout.
// ---------------------------------------------------------------------------
module splc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [splc_pkg::ADDR_W-1:0]   paddr,
  input  logic [splc_pkg::DATA_W-1:0]   pwdata,
  output logic [splc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output splc_pkg::cfg_t                cfg
);

  logic                               wr_en;
  logic [splc_pkg::REG_IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[splc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_voltage     <= splc_pkg::RST_MIN_VOLTAGE;
      cfg.max_voltage     <= splc_pkg::RST_MAX_VOLTAGE;
      cfg.voltage_offset  <= splc_pkg::RST_VOLTAGE_OFFSET;
      cfg.volts_per_level <= splc_pkg::RST_VOLTS_PER_LEVEL;
      cfg.min_level       <= splc_pkg::RST_MIN_LEVEL;
      cfg.max_level       <= splc_pkg::RST_MAX_LEVEL;
      cfg.timeout_ticks   <= splc_pkg::RST_TIMEOUT_TICKS;
    end else if (wr_en) begin
      case (idx)
        splc_pkg::REG_MIN_VOLTAGE:     cfg.min_voltage     <= pwdata[splc_pkg::VOLT_W-1:0];
        splc_pkg::REG_MAX_VOLTAGE:     cfg.max_voltage     <= pwdata[splc_pkg::VOLT_W-1:0];
        splc_pkg::REG_VOLTAGE_OFFSET:  cfg.voltage_offset  <= pwdata[splc_pkg::VOLT_W-1:0];
        splc_pkg::REG_VOLTS_PER_LEVEL: cfg.volts_per_level <= pwdata[splc_pkg::FACTOR_W-1:0];
        splc_pkg::REG_MIN_LEVEL:       cfg.min_level       <= pwdata[splc_pkg::LEVEL_W-1:0];
        splc_pkg::REG_MAX_LEVEL:       cfg.max_level       <= pwdata[splc_pkg::LEVEL_W-1:0];
        splc_pkg::REG_TIMEOUT_TICKS:   cfg.timeout_ticks   <= pwdata[splc_pkg::AGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      splc_pkg::REG_MIN_VOLTAGE:     prdata = splc_pkg::DATA_W'(cfg.min_voltage);
      splc_pkg::REG_MAX_VOLTAGE:     prdata = splc_pkg::DATA_W'(cfg.max_voltage);
      splc_pkg::REG_VOLTAGE_OFFSET:  prdata = splc_pkg::DATA_W'(cfg.voltage_offset);
      splc_pkg::REG_VOLTS_PER_LEVEL: prdata = splc_pkg::DATA_W'(cfg.volts_per_level);
      splc_pkg::REG_MIN_LEVEL:       prdata = splc_pkg::DATA_W'(cfg.min_level);
      splc_pkg::REG_MAX_LEVEL:       prdata = splc_pkg::DATA_W'(cfg.max_level);
      splc_pkg::REG_TIMEOUT_TICKS:   prdata = splc_pkg::DATA_W'(cfg.timeout_ticks);
      default:                       prdata = '0;
    endcase
  end

endmodule

[rtl/splc_frame.sv]
// ---------------------------------------------------------------------------
// splc_frame
// Frame assembler and checker: gathers four bytes, checks the XOR byte and
// counter continuity, keeps the last good voltage and the tick age.
// ---------------------------------------------------------------------------
module splc_frame (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          req_type,
  input  logic [splc_pkg::BYTE_W-1:0]   rx_byte,
  output splc_pkg::frame_stat_t         stat
);

  logic [splc_pkg::BYTE_W-1:0]   frame_bytes [0:2];
  logic [1:0]                    frame_fill;
  logic [splc_pkg::BYTE_W-1:0]   last_counter;
  logic                          has_previous;
  logic [splc_pkg::SAMPLE_W-1:0] stored_voltage;
  logic [splc_pkg::AGE_W-1:0]    tick_age;
  logic [splc_pkg::EVENT_W-1:0]  event_code;
  logic [splc_pkg::BYTE_W-1:0]   check;
  logic                          frame_end;

  assign check     = frame_bytes[0] ^ frame_bytes[1] ^ frame_bytes[2];
  assign frame_end = (frame_fill == 2'd3);

  // The byte store needs no reset: every entry is written before a check.
  always_ff @(posedge clk) begin
    if (take && (req_type == splc_pkg::REQ_BYTE) && !frame_end) begin
      frame_bytes[frame_fill] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_fill     <= '0;
      last_counter   <= '0;
      has_previous   <= 1'b0;
      stored_voltage <= '0;
      tick_age       <= '0;
      event_code     <= splc_pkg::EV_NONE;
    end else if (take) begin
      event_code <= splc_pkg::EV_NONE;
      if (req_type == splc_pkg::REQ_TICK) begin
        if (tick_age != '1) begin
          tick_age <= tick_age + 1'b1;
        end
      end else if (!frame_end) begin
        frame_fill <= frame_fill + 1'b1;
      end else begin
        frame_fill <= '0;
        if (check != rx_byte) begin
          event_code <= splc_pkg::EV_CHECKSUM;
        end else if (has_previous && (frame_bytes[0] != last_counter + 1'b1)) begin
          event_code <= splc_pkg::EV_COUNTER;
        end else begin
          event_code     <= splc_pkg::EV_ACCEPTED;
          stored_voltage <= {frame_bytes[1], frame_bytes[2]};
          last_counter   <= frame_bytes[0];
          has_previous   <= 1'b1;
          tick_age       <= '0;
        end
      end
    end
  end

  assign stat.event_code = event_code;
  assign stat.voltage    = stored_voltage;
  assign stat.tick_age   = tick_age;

endmodule

[rtl/splc_div.sv]
// ---------------------------------------------------------------------------
// splc_div
// Bit-serial restoring divider for unsigned magnitudes: one quotient bit a
// cycle, dividend shifted out of the top while quotient bits shift in.
// ---------------------------------------------------------------------------
module splc_div #(
  parameter int DividendW = splc_pkg::VOLT_W,
  parameter int DivisorW  = splc_pkg::FACTOR_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DividendW-1:0] dividend,
  input  logic [DivisorW-1:0]  divisor,
  output logic                 busy,
  output logic [DividendW-1:0] quotient
);

  localparam int CntW = $clog2(DividendW + 1);

  logic [CntW-1:0]      cnt;
  logic [DividendW-1:0] quo;
  logic [DivisorW-1:0]  rem;
  logic [DivisorW-1:0]  dvs;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;
  logic                 fits;

  assign trial = {rem, quo[DividendW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(DividendW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo <= {quo[DividendW-2:0], fits};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

[rtl/sensor_packet_receiver_level_conv.sv]
// ---------------------------------------------------------------------------
// sensor_packet_receiver_level_conv
// Sensor frame receiver with voltage-to-level conversion.
// ---------------------------------------------------------------------------
// The req channel carries one word per serial byte or per millisecond tick.
// Every accepted word yields exactly one result word on the rsp channel with
// the frame event, the timeout flag, the level status, the water level and
// the stored voltage. The APB port programs the limits, the offset, the
// conversion factor and the timeout; writes are expected only while idle.
// The frame state is updated at the accepting edge itself. After that an
// item passes through the load state, which registers the sign of the
// difference and starts the divider, then the bit-serial divider (one
// quotient bit per cycle over the 22-bit magnitude), then the output state,
// which forms the level and status and registers them. One item is in
// work at a time: no new word is taken until the previous result is loaded
// into the output register.
// The result sits in an output register; req is ready again as soon as the
// result is loaded, so the next word is taken while the previous result
// still waits. If rsp stalls, the finished level waits in its last state and
// the block takes no new word until the output register is free.
// Reset (rst, synchronous) clears the frame state, the tick age, the
// pending result and loads the register defaults.
// ---------------------------------------------------------------------------
module sensor_packet_receiver_level_conv (
  input  logic                          clk,
  input  logic                          rst,
  splc_in_if.sink                       req,
  splc_out_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [splc_pkg::ADDR_W-1:0]   paddr,
  input  logic [splc_pkg::DATA_W-1:0]   pwdata,
  output logic [splc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam int DiffW = splc_pkg::VOLT_W + 1;

  splc_pkg::cfg_t        cfg;
  splc_pkg::frame_stat_t stat;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;
  logic       out_load;

  // Sign and magnitude of the voltage minus the offset.
  logic [DiffW-1:0]               delta;
  logic [DiffW-1:0]               delta_abs;
  logic                           neg;
  logic [splc_pkg::FACTOR_W-1:0]  divisor;
  logic                           div_busy;
  logic [splc_pkg::VOLT_W-1:0]    quotient;

  // Level and range checks on the finished quotient.
  logic [splc_pkg::WLEVEL_W-1:0]  q_ext;
  logic [splc_pkg::WLEVEL_W-1:0]  base;
  logic [splc_pkg::WLEVEL_W-1:0]  level;
  logic                           volt_bad;
  logic                           below;
  logic                           above;
  logic [splc_pkg::STATUS_W-1:0]  status;

  // Output register.
  logic                           out_valid;
  logic [splc_pkg::EVENT_W-1:0]   out_event;
  logic                           out_timed;
  logic [splc_pkg::STATUS_W-1:0]  out_status;
  logic [splc_pkg::WLEVEL_W-1:0]  out_level;
  logic [splc_pkg::SAMPLE_W-1:0]  out_voltage;

  splc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign req.ready = (state == ST_IDLE);
  assign take      = req.valid && req.ready;

  splc_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .req_type (req.req_type),
    .rx_byte  (req.rx_byte),
    .stat     (stat)
  );

  // The stored voltage is registered at the accepting edge, so the divider is
  // started from the load state that follows acceptance.
  assign delta     = {{(DiffW - splc_pkg::SAMPLE_W){1'b0}}, stat.voltage}
                   - {1'b0, cfg.voltage_offset};
  assign delta_abs = delta[DiffW-1] ? (~delta + 1'b1) : delta;
  // A zero factor divides as one.
  assign divisor   = (cfg.volts_per_level == '0) ? splc_pkg::FACTOR_W'(1)
                                                 : cfg.volts_per_level;

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      neg <= delta[DiffW-1];
    end
  end

  splc_div #(
    .DividendW (splc_pkg::VOLT_W),
    .DivisorW  (splc_pkg::FACTOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_LOAD),
    .dividend (delta_abs[splc_pkg::VOLT_W-1:0]),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Truncation toward zero: the quotient of the magnitudes takes the sign of
  // the difference, so the level is the base plus or minus that quotient.
  assign q_ext = {{(splc_pkg::WLEVEL_W - splc_pkg::VOLT_W){1'b0}}, quotient};
  assign base  = {{(splc_pkg::WLEVEL_W - splc_pkg::LEVEL_W){1'b0}}, cfg.min_level};
  assign level = neg ? (base - q_ext) : (base + q_ext);

  assign volt_bad = ({{(splc_pkg::VOLT_W - splc_pkg::SAMPLE_W){1'b0}}, stat.voltage}
                     < cfg.min_voltage)
                 || ({{(splc_pkg::VOLT_W - splc_pkg::SAMPLE_W){1'b0}}, stat.voltage}
                     > cfg.max_voltage);
  // Only a negative nonzero quotient takes the level below its base.
  assign below = neg && (quotient != '0);
  assign above = $signed(level)
               > $signed({{(splc_pkg::WLEVEL_W - splc_pkg::LEVEL_W){1'b0}}, cfg.max_level});

  always_comb begin
    if (volt_bad) begin
      status = splc_pkg::LS_VOLT_RANGE;
    end else if (below || above) begin
      status = splc_pkg::LS_LEVEL_RANGE;
    end else begin
      status = splc_pkg::LS_OK;
    end
  end

  assign out_load = (state == ST_OUT) && (!out_valid || rsp.ready);

  always_comb begin
    case (state)
      ST_IDLE: state_next = take ? ST_LOAD : ST_IDLE;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  state_next = div_busy ? ST_DIV : ST_OUT;
      ST_OUT:  state_next = out_load ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_event   <= stat.event_code;
      out_timed   <= (stat.tick_age > cfg.timeout_ticks);
      out_status  <= status;
      out_level   <= volt_bad ? '0 : level;
      out_voltage <= stat.voltage;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.packet_event = out_event;
  assign rsp.timed_out    = out_timed;
  assign rsp.level_status = out_status;
  assign rsp.water_level  = out_level;
  assign rsp.voltage_out  = out_voltage;

endmodule

[rtl/splc_checker.sv]
// ---------------------------------------------------------------------------
// splc_checker
// Port-level checks of the sensor packet receiver, bound to its top level.
// ---------------------------------------------------------------------------
module splc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [splc_pkg::EVENT_W-1:0]  packet_event,
  input logic                          timed_out,
  input logic [splc_pkg::STATUS_W-1:0] level_status,
  input logic [splc_pkg::WLEVEL_W-1:0] water_level,
  input logic [splc_pkg::SAMPLE_W-1:0] voltage_out
);

  // A stalled result word stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({packet_event, timed_out, level_status,
                                         water_level, voltage_out}))
    else $error("result payload changed while stalled");

  // Reset drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word offered right after reset");

  // A voltage outside its window forces the level to zero.
  a_volt_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (level_status == splc_pkg::LS_VOLT_RANGE) |-> (water_level == '0))
    else $error("level not cleared for a voltage out of range");

  // A valid level is never below its nonnegative base.
  a_ok_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && (level_status == splc_pkg::LS_OK) |-> !water_level[splc_pkg::WLEVEL_W-1])
    else $error("negative level reported as valid");

endmodule

bind sensor_packet_receiver_level_conv splc_checker u_splc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .packet_event (rsp.packet_event),
  .timed_out    (rsp.timed_out),
  .level_status (rsp.level_status),
  .water_level  (rsp.water_level),
  .voltage_out  (rsp.voltage_out)
);

[bench/sensor_packet_receiver_level_conv_test.sv]
// ---------------------------------------------------------------------------
// sensor_packet_receiver_level_conv_test
// Self-checking bench for the sensor packet receiver with level conversion.
// ---------------------------------------------------------------------------
// Serial bytes and millisecond ticks go in on the request channel, one word
// per handshake. A mirror of the receiver, kept in a small class, follows
// every accepted word and computes the result word the block must return.
// Returned words are compared field by field in arrival order. The run starts
// with a short directed sequence and then goes through a series of register
// settings, each followed by random traffic built mostly from well-formed
// frames. Both channels idle at random, and once the result side holds off
// long enough for the block to back up onto its input.
// ---------------------------------------------------------------------------
module sensor_packet_receiver_level_conv_test;
  import splc_pkg::*;

  localparam int HALF_PERIOD     = 2;
  localparam int RESET_CYCLES    = 6;
  // Margin left after draining, before the next register writes.
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 92;
  localparam int HOLD_OFF_AT     = 250;
  localparam int HOLD_OFF_CYCLES = 600;

  // Index 7 has no register behind it; writes there must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [EVENT_W-1:0]         packet_event;
    logic                       timed_out;
    logic [STATUS_W-1:0]        level_status;
    logic signed [WLEVEL_W-1:0] water_level;
    logic [SAMPLE_W-1:0]        voltage_out;
  } result_word_t;

  // Mirror of the receiver: register copy, framing state, and the queue of
  // result words still owed by the block.
  class receiver_mirror;
    cfg_t                regs;
    logic [BYTE_W-1:0]   frame_bytes [3];
    int unsigned         frame_fill;
    logic [BYTE_W-1:0]   last_counter;
    bit                  has_previous;
    logic [SAMPLE_W-1:0] stored_voltage;
    logic [AGE_W-1:0]    tick_age;
    result_word_t        pending_results [$];
    int                  errors;
    int                  compared;
    int                  words;
    int                  ticks;
    int                  event_count [4];
    int                  status_count [4];

    function new();
      regs.min_voltage     = RST_MIN_VOLTAGE;
      regs.max_voltage     = RST_MAX_VOLTAGE;
      regs.voltage_offset  = RST_VOLTAGE_OFFSET;
      regs.volts_per_level = RST_VOLTS_PER_LEVEL;
      regs.min_level       = RST_MIN_LEVEL;
      regs.max_level       = RST_MAX_LEVEL;
      regs.timeout_ticks   = RST_TIMEOUT_TICKS;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      frame_fill     = 0;
      last_counter   = '0;
      has_previous   = 0;
      stored_voltage = '0;
      tick_age       = '0;
      errors         = 0;
      compared       = 0;
      words          = 0;
      ticks          = 0;
      foreach (event_count[i]) event_count[i] = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_MIN_VOLTAGE:     regs.min_voltage     = data[VOLT_W-1:0];
        REG_MAX_VOLTAGE:     regs.max_voltage     = data[VOLT_W-1:0];
        REG_VOLTAGE_OFFSET:  regs.voltage_offset  = data[VOLT_W-1:0];
        REG_VOLTS_PER_LEVEL: regs.volts_per_level = data[FACTOR_W-1:0];
        REG_MIN_LEVEL:       regs.min_level       = data[LEVEL_W-1:0];
        REG_MAX_LEVEL:       regs.max_level       = data[LEVEL_W-1:0];
        REG_TIMEOUT_TICKS:   regs.timeout_ticks   = data[AGE_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_word(logic kind, logic [BYTE_W-1:0] b);
      result_word_t       r;
      logic [EVENT_W-1:0] ev;
      logic [BYTE_W-1:0]  check;
      int                 delta;
      int                 divisor;
      int                 lvl;
      ev  = EV_NONE;
      lvl = 0;
      words++;
      if (kind == REQ_TICK) begin
        ticks++;
        if (tick_age != '1) tick_age++;
      end else if (frame_fill < 3) begin
        frame_bytes[frame_fill] = b;
        frame_fill++;
      end else begin
        frame_fill = 0;
        check = frame_bytes[0] ^ frame_bytes[1] ^ frame_bytes[2];
        if (check != b) begin
          ev = EV_CHECKSUM;
        end else if (has_previous && frame_bytes[0] != BYTE_W'(last_counter + 1)) begin
          ev = EV_COUNTER;
        end else begin
          ev             = EV_ACCEPTED;
          stored_voltage = {frame_bytes[1], frame_bytes[2]};
          last_counter   = frame_bytes[0];
          has_previous   = 1;
          tick_age       = '0;
        end
      end
      r.packet_event = ev;
      r.timed_out    = (tick_age > regs.timeout_ticks);
      if (stored_voltage < regs.min_voltage || stored_voltage > regs.max_voltage) begin
        r.level_status = LS_VOLT_RANGE;
      end else begin
        delta   = int'(stored_voltage) - int'(regs.voltage_offset);
        divisor = (regs.volts_per_level == '0) ? 1 : int'(regs.volts_per_level);
        lvl     = int'(regs.min_level) + delta / divisor;
        if (lvl < int'(regs.min_level) || lvl > int'(regs.max_level)) begin
          r.level_status = LS_LEVEL_RANGE;
        end else begin
          r.level_status = LS_OK;
        end
      end
      r.water_level = WLEVEL_W'(lvl);
      r.voltage_out = stored_voltage;
      event_count[ev]++;
      status_count[r.level_status]++;
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic signed [WLEVEL_W:0] want,
                              logic signed [WLEVEL_W:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void compare_result(result_word_t got);
      result_word_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual event %0d level %0d",
                 $time, got.packet_event, got.water_level);
        return;
      end
      want = pending_results.pop_front();
      compared++;
      check_field("packet_event", want.packet_event, got.packet_event);
      check_field("timed_out", want.timed_out, got.timed_out);
      check_field("level_status", want.level_status, got.level_status);
      check_field("water_level", want.water_level, got.water_level);
      check_field("voltage_out", want.voltage_out, got.voltage_out);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  splc_in_if  req_ch ();
  splc_out_if rsp_ch ();

  receiver_mirror mirror = new();

  int unsigned cycle_count = 0;
  int          burst_left = 0;
  bit          steady_sender = 0;

  sensor_packet_receiver_level_conv DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Watchdog. The limit is several times the slowest legal run, including the
  // long hold-off on the result side.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles with %0d result words outstanding.",
               cycle_count, mirror.pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one word and waits for the handshake. The sender works in bursts:
  // when a burst runs out, valid drops for a random gap, empty at times and
  // always for a steady sender, before the next one. Signals are sampled right
  // after the edge, so they still hold the values that the edge itself saw.
  task automatic send_word(input logic kind, input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (steady_sender) begin
        gap = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(10, 40);
      end else begin
        gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.rx_byte  <= b;
    do @(posedge clk); while (!req_ch.ready);
    mirror.take_word(kind, b);
  endtask

  // A frame is counter, voltage high, voltage low and the XOR check. A nonzero
  // flip corrupts the check; a tick may be slipped in between the data bytes,
  // which must not disturb the framing.
  task automatic send_frame(input logic [BYTE_W-1:0] counter,
                            input logic [SAMPLE_W-1:0] volts,
                            input logic [BYTE_W-1:0] flip, input bit tick_inside);
    logic [BYTE_W-1:0] check;
    check = counter ^ volts[15:8] ^ volts[7:0] ^ flip;
    send_word(REQ_BYTE, counter);
    send_word(REQ_BYTE, volts[15:8]);
    if (tick_inside) send_word(REQ_TICK, BYTE_W'($urandom));
    send_word(REQ_BYTE, volts[7:0]);
    send_word(REQ_BYTE, check);
  endtask

  // Setup cycle, then access cycle; the write lands at the edge where pready
  // is seen high. An idle cycle follows so back-to-back writes never assign
  // psel twice in the same step.
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Registers only keep their low bits, so random junk above the field must
  // be dropped by the block.
  function automatic logic [DATA_W-1:0] with_junk(int unsigned value, int width);
    logic [DATA_W-1:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 1) == 1) return DATA_W'(value) | (junk << width);
    return DATA_W'(value);
  endfunction

  task automatic set_limits(input int unsigned min_v, input int unsigned max_v,
                            input int unsigned offset, input int unsigned factor,
                            input int unsigned lo_level, input int unsigned hi_level,
                            input int unsigned timeout);
    cfg_write(REG_MIN_VOLTAGE, with_junk(min_v, VOLT_W));
    cfg_write(REG_MAX_VOLTAGE, with_junk(max_v, VOLT_W));
    cfg_write(REG_VOLTAGE_OFFSET, with_junk(offset, VOLT_W));
    cfg_write(REG_VOLTS_PER_LEVEL, with_junk(factor, FACTOR_W));
    cfg_write(REG_MIN_LEVEL, with_junk(lo_level, LEVEL_W));
    cfg_write(REG_MAX_LEVEL, with_junk(hi_level, LEVEL_W));
    cfg_write(REG_TIMEOUT_TICKS, with_junk(timeout, AGE_W));
    cfg_write(REG_UNUSED, $urandom);
  endtask

  // Stops offering and waits until every owed result word has come back, then
  // lets the pipeline settle before registers are touched again.
  task automatic drain;
    req_ch.valid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random traffic. Most of it is well-formed frames carrying the next counter,
  // with some checksum and counter errors, tick bursts, and stray bytes that
  // knock the framing out of step. Before a frame, filler bytes bring the
  // framing back into step so the frame itself lands where intended.
  task automatic run_random(input int count);
    int                  stop_at;
    int                  pick;
    logic [BYTE_W-1:0]   counter;
    logic [BYTE_W-1:0]   flip;
    logic [SAMPLE_W-1:0] volts;
    stop_at = mirror.words + count;
    while (mirror.words < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 12)) send_word(REQ_TICK, BYTE_W'($urandom));
      end else if (pick < 15) begin
        send_word(REQ_BYTE, BYTE_W'($urandom));
      end else begin
        while (mirror.frame_fill != 0) send_word(REQ_BYTE, BYTE_W'($urandom));
        pick    = $urandom_range(0, 9);
        counter = BYTE_W'(mirror.last_counter + 1);
        flip    = '0;
        if (pick == 8) counter = BYTE_W'(mirror.last_counter + $urandom_range(2, 256));
        if (pick == 9) flip = BYTE_W'(1 << $urandom_range(0, 7));
        // Voltages cluster at the ends of the range and around the limits.
        case ($urandom_range(0, 5))
          0:       volts = '0;
          1:       volts = '1;
          2:       volts = SAMPLE_W'(mirror.regs.min_voltage) + SAMPLE_W'($urandom_range(0, 4)) - 2;
          3:       volts = SAMPLE_W'(mirror.regs.max_voltage) + SAMPLE_W'($urandom_range(0, 4)) - 2;
          default: volts = SAMPLE_W'($urandom);
        endcase
        send_frame(counter, volts, flip, $urandom_range(0, 4) == 0);
      end
    end
  endtask

  // Result side. Ready steps in turn through four patterns: always ready,
  // random half, rare, and a fixed duty cycle. After a number of words
  // it holds off once for a long stretch so the block fills and stalls input.
  initial begin : result_sink
    int           hold_left;
    bit           hold_done;
    result_word_t got;
    hold_left    = 0;
    hold_done    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.packet_event = rsp_ch.packet_event;
        got.timed_out    = rsp_ch.timed_out;
        got.level_status = rsp_ch.level_status;
        got.water_level  = rsp_ch.water_level;
        got.voltage_out  = rsp_ch.voltage_out;
        mirror.compare_result(got);
      end
      if (!hold_done && mirror.compared >= HOLD_OFF_AT) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case ((cycle_count / 150) % 4)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 1) == 0);
          2:       rsp_ch.ready <= ($urandom_range(0, 4) == 0);
          default: rsp_ch.ready <= ((cycle_count % 7) < 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned min_v;
    int unsigned max_v;
    int unsigned lo_level;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_BYTE;
    req_ch.rx_byte  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With the reset limits no 16-bit voltage is in range, so the first frame
    // is accepted (any counter goes for the first one) but reports a voltage
    // out of range.
    send_frame(8'hFD, 16'h0000, 8'h00, 0);
    drain;

    // Wide-open limits with a divisor of one and a one-tick timeout.
    set_limits(0, 22'h3FFFFF, 0, 1, 0, 16'hFFFF, 1);
    send_frame(8'hFE, 16'hFFFF, 8'h00, 0);
    // Two ticks push the age past the timeout; the frame around the second
    // one carries a bad check and must leave the stored voltage alone.
    send_word(REQ_TICK, 8'hFF);
    send_frame(8'hFF, 16'h8000, 8'h01, 1);
    // Good check but the counter skips ahead.
    send_frame(8'h07, 16'h00FF, 8'h00, 0);
    // The right counter clears the age; the next one wraps to zero.
    send_frame(8'hFF, 16'h1234, 8'h00, 0);
    drain;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady_sender = (p % 4 == 3);
      case (p)
        // Only zero voltage in range, a zero divisor taken as one, and level
        // limits crossed so every computed level is out of range.
        0: set_limits(0, 0, 22'h3FFFFF, 0, 16'hFFFF, 0, 0);
        // Limits above any 16-bit voltage, the largest divisor, and a timeout one below its largest value.
        1: set_limits(22'h3FFFFF, 22'h3FFFFF, 0, 16'hFFFF, 0, 0, 65534);
        default: begin
          min_v    = $urandom_range(0, 30000);
          max_v    = ($urandom_range(0, 3) == 0) ? 22'h3FFFFF : min_v + $urandom_range(0, 40000);
          lo_level = $urandom_range(0, 300);
          set_limits(min_v, max_v, $urandom_range(0, 60000),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                 : $urandom_range(1, 400),
                     lo_level,
                     ($urandom_range(0, 4) == 0) ? 16'hFFFF : lo_level + $urandom_range(0, 1500),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65534)
                                                 : $urandom_range(0, 8));
        end
      endcase
      run_random(WORDS_PER_PHASE);
      drain;
    end

    $display("Sent %0d words (%0d ticks) over %0d register settings; frames accepted %0d, %s %0d, %s %0d.",
             mirror.words, mirror.ticks, RANDOM_PHASES + 2, mirror.event_count[EV_ACCEPTED],
             "bad checks", mirror.event_count[EV_CHECKSUM],
             "counter skips", mirror.event_count[EV_COUNTER]);
    $display("Level valid %0d, voltage out of range %0d, level out of range %0d; %0d words compared.",
             mirror.status_count[LS_OK], mirror.status_count[LS_VOLT_RANGE],
             mirror.status_count[LS_LEVEL_RANGE], mirror.compared);
    if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
